@@ design/uwtack_pkg.sv @@
// Shared types and constants for the upwind tack course selector.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps
`default_nettype none

package uwtack_pkg;

  // Heading and register widths
  localparam int ANGLE_W = 9;
  localparam int REG_W   = 8;

  // One full turn; headings live in 0..DEG_FULL-1
  localparam logic [ANGLE_W:0] DEG_FULL = 10'd360;

  // Register reset values
  localparam logic [REG_W-1:0] TACK_RESET   = 8'd45;
  localparam logic [REG_W-1:0] SECTOR_RESET = 8'd20;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TACK   = 1'b0,
    CFG_SECTOR = 1'b1
  } cfg_idx_t;

  // Input transaction
  typedef struct packed {
    logic [ANGLE_W-1:0] wind_dir;
    logic [ANGLE_W-1:0] bearing;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [ANGLE_W-1:0] course;
    logic               tacking;
    logic               on_starboard;
  } out_t;

  // Geometry of one item, handed to the side control
  typedef struct packed {
    logic [ANGLE_W-1:0] bearing;
    logic [ANGLE_W-1:0] star_course;
    logic [ANGLE_W-1:0] port_course;
    logic               tacking;
    logic               star_pick;
    logic               star_leave;
    logic               port_leave;
  } geom_t;

endpackage

`default_nettype wire

@@ design/uwtack_geom.sv @@
// Heading geometry: zone test, both tack courses and hysteresis tests.
// Pure combinational logic; depends on uwtack_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uwtack_geom (
  input  wire uwtack_pkg::in_t        item,
  input  wire logic [7:0]             tack_angle,
  input  wire logic [7:0]             sector_angle,
  output uwtack_pkg::geom_t           geo
);
  import uwtack_pkg::*;

  // Fold a 9-bit angle into 0..359
  function automatic logic [ANGLE_W-1:0] wrap_angle(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W:0] t;
    t = {1'b0, a};
    if (t >= DEG_FULL) t = t - DEG_FULL;
    return t[ANGLE_W-1:0];
  endfunction

  // Clockwise distance from b to a, both in 0..359
  function automatic logic [ANGLE_W-1:0] cw_offset(input logic [ANGLE_W-1:0] a,
                                                   input logic [ANGLE_W-1:0] b);
    logic [ANGLE_W:0] d;
    d = {1'b0, a} + DEG_FULL - {1'b0, b};
    if (d >= DEG_FULL) d = d - DEG_FULL;
    return d[ANGLE_W-1:0];
  endfunction

  logic [ANGLE_W-1:0] w;
  logic [ANGLE_W-1:0] b;
  logic [ANGLE_W-1:0] up;
  logic [ANGLE_W-1:0] down;
  logic [ANGLE_W-1:0] tack_ext;
  logic [ANGLE_W-1:0] hold;
  logic               up_in;
  logic               down_in;
  logic [ANGLE_W-1:0] n_star;
  logic [ANGLE_W-1:0] n_port;
  logic [ANGLE_W:0]   star_sum;
  logic [ANGLE_W:0]   port_diff;
  logic [ANGLE_W-1:0] star_c;
  logic [ANGLE_W-1:0] port_c;

  // Offsets of the bearing on either side of the wind
  assign w        = wrap_angle(item.wind_dir);
  assign b        = wrap_angle(item.bearing);
  assign up       = cw_offset(b, w);
  assign down     = cw_offset(w, b);
  assign tack_ext = {1'b0, tack_angle};
  assign hold     = {1'b0, tack_angle} + {1'b0, sector_angle};
  assign up_in    = up < tack_ext;
  assign down_in  = down < tack_ext;

  // Step counts toward the bearing; a tie goes to starboard
  assign n_star = up_in   ? up + 9'd1   : tack_ext;
  assign n_port = down_in ? down + 9'd1 : tack_ext;

  // Close-hauled courses on each side
  always_comb begin
    star_sum = {1'b0, w} + {2'b00, tack_angle};
    if (star_sum >= DEG_FULL) star_sum = star_sum - DEG_FULL;
    star_c = star_sum[ANGLE_W-1:0];
    if ({1'b0, w} >= {2'b00, tack_angle}) begin
      port_diff = {1'b0, w} - {2'b00, tack_angle};
    end else begin
      port_diff = {1'b0, w} + DEG_FULL - {2'b00, tack_angle};
    end
    port_c = port_diff[ANGLE_W-1:0];
  end

  // Hand the geometry on
  always_comb begin
    geo.bearing     = b;
    geo.star_course = star_c;
    geo.port_course = port_c;
    geo.tacking     = up_in || down_in;
    geo.star_pick   = !(n_port > n_star);
    geo.star_leave  = cw_offset(star_c, b) >= hold;
    geo.port_leave  = cw_offset(b, port_c) >= hold;
  end

endmodule

`default_nettype wire

@@ design/uwtack_ctrl.sv @@
// Tack side state and course selection for one item per cycle while en is high.
// Holds was_tacking and starboard_side; depends on uwtack_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uwtack_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire uwtack_pkg::geom_t   geo,
  output uwtack_pkg::out_t         result
);
  import uwtack_pkg::*;

  logic was_tacking;
  logic starboard_side;
  logic starboard_side_next;

  // Pick the side: fresh choice on entry, hysteresis while in the zone
  always_comb begin
    starboard_side_next = starboard_side;
    if (geo.tacking) begin
      if (!was_tacking) begin
        starboard_side_next = geo.star_pick;
      end else if (starboard_side) begin
        if (geo.star_leave) starboard_side_next = 1'b0;
      end else begin
        if (geo.port_leave) starboard_side_next = 1'b1;
      end
    end
  end

  // Build the result
  always_comb begin
    result.tacking      = geo.tacking;
    result.on_starboard = starboard_side_next;
    if (!geo.tacking) begin
      result.course = geo.bearing;
    end else if (starboard_side_next) begin
      result.course = geo.star_course;
    end else begin
      result.course = geo.port_course;
    end
  end

  // Advance the side state with each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      was_tacking    <= 1'b0;
      starboard_side <= 1'b0;
    end else if (en) begin
      was_tacking    <= geo.tacking;
      starboard_side <= starboard_side_next;
    end
  end

endmodule

`default_nettype wire

@@ design/upwind_tack_course_selector.sv @@
// Upwind tack course selector, top level.
// Accepted inputs pass through the input register, which feeds the result register.
// Throughput: one transaction per cycle unless stalled; uwtack_ctrl's side state loop sets it.
// An empty input register takes a new item while a finished result waits on out_stall.
// Synchronous reset clears both valid flags and the side state, and loads
// tack_angle = 45 and sector_angle = 20.
`timescale 1ns / 1ps
`default_nettype none

module upwind_tack_course_selector (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [uwtack_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [uwtack_pkg::REG_W-1:0]           cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire uwtack_pkg::in_t                        in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output uwtack_pkg::out_t                            out_data
);
  import uwtack_pkg::*;

  logic [REG_W-1:0] tack_angle;
  logic [REG_W-1:0] sector_angle;
  logic             s1_valid;
  in_t              s1_data;
  logic             advance;
  logic             fire;
  geom_t            geo;
  out_t             result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tack_angle   <= TACK_RESET;
      sector_angle <= SECTOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TACK:   tack_angle   <= cfg_data;
        CFG_SECTOR: sector_angle <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Flow control: result register frees up when empty or taken
  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) s1_data <= in_data;
  end

  uwtack_geom u_geom (
    .item         (s1_data),
    .tack_angle   (tack_angle),
    .sector_angle (sector_angle),
    .geo          (geo)
  );

  uwtack_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .en     (fire),
    .geo    (geo),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data <= result;
  end

  // Checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_stall_needs_block: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register can move");

  a_fire_fills_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("transaction lost between input and result register");

  a_course_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_data.course} < DEG_FULL))
    else $error("course out of range");

endmodule

`default_nettype wire
